### sv/vnc_pkg.sv
// Shared types and constants for the voxel normal consistency filter.
// No dependencies; imported by vnc_dot_check and the top level.
`default_nettype none

package vnc_pkg;

    localparam int TAG_W  = 16;
    localparam int NORM_W = 16;
    localparam int KEY_W  = 48;
    localparam int SUM_W  = 24;
    localparam int PROD_W = NORM_W + SUM_W;
    localparam int DOT_W  = PROD_W + 2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // one buffered point: tag and normal
    typedef struct packed {
        logic        [TAG_W-1:0]  tag;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } vnc_entry_t;

    // running normal sum of the open group
    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } vnc_sum_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_FINAL
    } vnc_state_t;

    // saturating add of one normal component to a sum
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  acc,
        input logic signed [NORM_W-1:0] add
    );
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(acc) + (SUM_W+1)'(add);
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/vnc_dot_check.sv
// Dot product of one buffered normal with the group sum, sign test.
// Depends on vnc_pkg (vnc_entry_t, vnc_sum_t, widths).
`default_nettype none

module vnc_dot_check (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              valid_in,
    input  wire vnc_pkg::vnc_entry_t entry_in,
    input  wire vnc_pkg::vnc_sum_t   sum_in,
    output logic                   valid_out,
    output logic [vnc_pkg::TAG_W-1:0] tag_out,
    output logic                   keep
);
    import vnc_pkg::*;

    logic                     valid_reg;
    logic [TAG_W-1:0]         tag_reg;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [PROD_W-1:0] pz_reg;
    logic signed [DOT_W-1:0]  dot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    // three narrow products side by side, registered before the sum
    always_ff @(posedge aclk) begin
        if (en) begin
            tag_reg <= entry_in.tag;
            px_reg  <= PROD_W'(entry_in.nx) * PROD_W'(sum_in.x);
            py_reg  <= PROD_W'(entry_in.ny) * PROD_W'(sum_in.y);
            pz_reg  <= PROD_W'(entry_in.nz) * PROD_W'(sum_in.z);
        end
    end

    assign dot       = DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
    assign valid_out = valid_reg;
    assign tag_out   = tag_reg;
    assign keep      = valid_reg && !dot[DOT_W-1];

endmodule

`default_nettype wire

### sv/voxel_normal_consistency_filter_unit.sv
// Top level of the voxel normal consistency filter: group buffer, sums, control.
// Depends on vnc_pkg and vnc_dot_check.
//
// Usage:
//   s_ channel: one beat per point, sorted by voxel key. s_tlast marks the final
//   point of the stream and forces the open group out after it is added.
//   m_ channel: one beat per kept point: tag in m_tdata, group overflow in
//   m_tuser; m_tlast is set on the final beat that one input point caused.
// Sequencing:
//   A point that neither closes a group nor carries tlast passes through
//   accept, the write into the group buffer with the sum update and a wrap-up
//   state. A flush scans the buffer at one entry per cycle, unless the output
//   stalls, through the read and multiply pipeline. A point that closes a group
//   first flushes the old group and is then added; an end of stream after a key
//   change gives two flushes for the one point.
// Reset: synchronous, aresetn low; the group is empty and no beat is pending.
//   Buffer contents are not cleared: only entries written in the current
//   group are ever read back.
// Stalls: one kept result is held back until the next (or the wrap-up of the
//   input point that caused it) is known, to place m_tlast; the scan halts while
//   a new kept result meets this held result and a full output with m_tready low.
`default_nettype none

module voxel_normal_consistency_filter_unit #(
    parameter int GROUP_DEPTH = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // s_tdata, lowest bit up: point_tag, voxel_x, voxel_y, voxel_z,
    //                         normal_x, normal_y, normal_z
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [111:0] s_tdata,
    input  wire logic         s_tlast,
    // m_tdata: kept_tag; m_tuser: group_overflow; m_tlast: last_of_run
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);
    import vnc_pkg::*;

    localparam int IDX_W = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int CNT_W = $clog2(GROUP_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(GROUP_DEPTH);

    // group buffer
    vnc_entry_t group_mem [GROUP_DEPTH];
    vnc_entry_t rd_entry_reg;

    vnc_state_t       state_reg, state_next;
    logic             phase_reg, phase_next;     // 1: flush after tlast
    vnc_entry_t       hold_entry_reg, hold_entry_next;
    logic [KEY_W-1:0] hold_key_reg, hold_key_next;
    logic             hold_last_reg, hold_last_next;

    logic [KEY_W-1:0] group_key_reg, group_key_next;
    logic [CNT_W-1:0] group_count_reg, group_count_next;
    logic             group_open_reg, group_open_next;
    vnc_sum_t         sum_reg, sum_next;
    logic             overflow_reg, overflow_next;

    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_valid_reg, rd_valid_next;

    logic             pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0] pend_tag_reg, pend_tag_next;
    logic             pend_ovf_reg, pend_ovf_next;

    logic             out_valid_reg, out_valid_next;
    logic [TAG_W-1:0] out_tag_reg, out_tag_next;
    logic             out_ovf_reg, out_ovf_next;
    logic             out_last_reg, out_last_next;

    vnc_entry_t       in_entry;
    logic [KEY_W-1:0] in_key;
    logic             in_beat;
    logic             has_space;
    logic             adv;
    logic             issue;
    logic             scan_done;
    logic             out_free;
    logic             dot_valid;
    logic [TAG_W-1:0] dot_tag;
    logic             dot_keep;

    assign in_entry.tag = s_tdata[15:0];
    assign in_entry.nx  = s_tdata[79:64];
    assign in_entry.ny  = s_tdata[95:80];
    assign in_entry.nz  = s_tdata[111:96];
    assign in_key       = s_tdata[63:16];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign has_space = (group_count_reg < DEPTH_C);
    assign out_free  = !out_valid_reg || m_tready;

    // a kept result with one already held needs the output register
    assign adv       = !(dot_keep && pend_valid_reg && !out_free);
    assign issue     = (state_reg == ST_SCAN) && (rd_idx_reg < group_count_reg) && adv;
    assign scan_done = (state_reg == ST_SCAN) && !(rd_idx_reg < group_count_reg)
                       && !rd_valid_reg && !dot_valid;

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_ADD) && has_space) begin
            group_mem[group_count_reg[IDX_W-1:0]] <= hold_entry_reg;
        end
        if (issue) begin
            rd_entry_reg <= group_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    vnc_dot_check u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .valid_in  (rd_valid_reg),
        .entry_in  (rd_entry_reg),
        .sum_in    (sum_reg),
        .valid_out (dot_valid),
        .tag_out   (dot_tag),
        .keep      (dot_keep)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= 1'b0;
            group_key_reg   <= '0;
            group_count_reg <= '0;
            group_open_reg  <= 1'b0;
            sum_reg         <= '0;
            overflow_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            rd_valid_reg    <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            group_key_reg   <= group_key_next;
            group_count_reg <= group_count_next;
            group_open_reg  <= group_open_next;
            sum_reg         <= sum_next;
            overflow_reg    <= overflow_next;
            rd_idx_reg      <= rd_idx_next;
            rd_valid_reg    <= rd_valid_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_entry_reg <= hold_entry_next;
        hold_key_reg   <= hold_key_next;
        hold_last_reg  <= hold_last_next;
        pend_tag_reg   <= pend_tag_next;
        pend_ovf_reg   <= pend_ovf_next;
        out_tag_reg    <= out_tag_next;
        out_ovf_reg    <= out_ovf_next;
        out_last_reg   <= out_last_next;
    end

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        hold_entry_next  = hold_entry_reg;
        hold_key_next    = hold_key_reg;
        hold_last_next   = hold_last_reg;
        group_key_next   = group_key_reg;
        group_count_next = group_count_reg;
        group_open_next  = group_open_reg;
        sum_next         = sum_reg;
        overflow_next    = overflow_reg;
        rd_idx_next      = rd_idx_reg;
        rd_valid_next    = adv ? issue : rd_valid_reg;
        pend_valid_next  = pend_valid_reg;
        pend_tag_next    = pend_tag_reg;
        pend_ovf_next    = pend_ovf_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_tag_next     = out_tag_reg;
        out_ovf_next     = out_ovf_reg;
        out_last_next    = out_last_reg;

        if (issue) begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end

        // kept result: the held one moves on, the new one is held
        if (adv && dot_keep) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_tag_next   = pend_tag_reg;
                out_ovf_next   = pend_ovf_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_tag_next   = dot_tag;
            pend_ovf_next   = overflow_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    hold_entry_next = in_entry;
                    hold_key_next   = in_key;
                    hold_last_next  = s_tlast;
                    rd_idx_next     = '0;
                    if (group_open_reg && (in_key != group_key_reg)) begin
                        phase_next = 1'b0;
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                group_key_next  = hold_key_reg;
                group_open_next = 1'b1;
                sum_next.x      = sat_add(sum_reg.x, hold_entry_reg.nx);
                sum_next.y      = sat_add(sum_reg.y, hold_entry_reg.ny);
                sum_next.z      = sat_add(sum_reg.z, hold_entry_reg.nz);
                if (has_space) begin
                    group_count_next = group_count_reg + 1'b1;
                end else begin
                    overflow_next = 1'b1;
                end
                rd_idx_next = '0;
                if (hold_last_reg) begin
                    phase_next = 1'b1;
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    group_key_next   = '0;
                    group_count_next = '0;
                    group_open_next  = 1'b0;
                    sum_next         = '0;
                    overflow_next    = 1'b0;
                    state_next       = phase_reg ? ST_FINAL : ST_ADD;
                end
            end
            ST_FINAL: begin
                // the held result is the last one this point caused
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_tag_next    = pend_tag_reg;
                    out_ovf_next    = pend_ovf_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tag_reg;
    assign m_tuser  = out_ovf_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire
